/* hw/rtl/sha256_pkg.sv */
`timescale 1ns / 1ps
package sha256_pkg;

    typedef logic [31:0] t_word;
    typedef logic [7:0][31:0] t_hash;

    typedef struct packed {
        logic [7:0] msg_byte;
        logic       byte_present;
        logic       end_of_message;
    } t_in_word;

    typedef struct packed {
        logic [63:0] digest_high;
        logic [63:0] digest_upper_mid;
        logic [63:0] digest_lower_mid;
        logic [63:0] digest_low;
        logic        length_error;
    } t_out_word;

    localparam logic [7:0] PAD_LEAD_BYTE = 8'h80;
    localparam logic [5:0] LEN_FIELD_START = 6'd56;

    localparam t_hash INIT_HASH = {
        32'h5BE0CD19, 32'h1F83D9AB, 32'h9B05688C, 32'h510E527F,
        32'hA54FF53A, 32'h3C6EF372, 32'hBB67AE85, 32'h6A09E667
    };

    function automatic t_word rotr(input t_word x, input int n);
        rotr = (x >> n) | (x << (32 - n));
    endfunction

    function automatic t_word small_sig0(input t_word x);
        small_sig0 = rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
    endfunction

    function automatic t_word small_sig1(input t_word x);
        small_sig1 = rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
    endfunction

    function automatic t_word big_sig0(input t_word x);
        big_sig0 = rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
    endfunction

    function automatic t_word big_sig1(input t_word x);
        big_sig1 = rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
    endfunction

    function automatic t_word round_const(input logic [5:0] t);
        case (t)
            6'd0:  round_const = 32'h428A2F98;  6'd1:  round_const = 32'h71374491;
            6'd2:  round_const = 32'hB5C0FBCF;  6'd3:  round_const = 32'hE9B5DBA5;
            6'd4:  round_const = 32'h3956C25B;  6'd5:  round_const = 32'h59F111F1;
            6'd6:  round_const = 32'h923F82A4;  6'd7:  round_const = 32'hAB1C5ED5;
            6'd8:  round_const = 32'hD807AA98;  6'd9:  round_const = 32'h12835B01;
            6'd10: round_const = 32'h243185BE;  6'd11: round_const = 32'h550C7DC3;
            6'd12: round_const = 32'h72BE5D74;  6'd13: round_const = 32'h80DEB1FE;
            6'd14: round_const = 32'h9BDC06A7;  6'd15: round_const = 32'hC19BF174;
            6'd16: round_const = 32'hE49B69C1;  6'd17: round_const = 32'hEFBE4786;
            6'd18: round_const = 32'h0FC19DC6;  6'd19: round_const = 32'h240CA1CC;
            6'd20: round_const = 32'h2DE92C6F;  6'd21: round_const = 32'h4A7484AA;
            6'd22: round_const = 32'h5CB0A9DC;  6'd23: round_const = 32'h76F988DA;
            6'd24: round_const = 32'h983E5152;  6'd25: round_const = 32'hA831C66D;
            6'd26: round_const = 32'hB00327C8;  6'd27: round_const = 32'hBF597FC7;
            6'd28: round_const = 32'hC6E00BF3;  6'd29: round_const = 32'hD5A79147;
            6'd30: round_const = 32'h06CA6351;  6'd31: round_const = 32'h14292967;
            6'd32: round_const = 32'h27B70A85;  6'd33: round_const = 32'h2E1B2138;
            6'd34: round_const = 32'h4D2C6DFC;  6'd35: round_const = 32'h53380D13;
            6'd36: round_const = 32'h650A7354;  6'd37: round_const = 32'h766A0ABB;
            6'd38: round_const = 32'h81C2C92E;  6'd39: round_const = 32'h92722C85;
            6'd40: round_const = 32'hA2BFE8A1;  6'd41: round_const = 32'hA81A664B;
            6'd42: round_const = 32'hC24B8B70;  6'd43: round_const = 32'hC76C51A3;
            6'd44: round_const = 32'hD192E819;  6'd45: round_const = 32'hD6990624;
            6'd46: round_const = 32'hF40E3585;  6'd47: round_const = 32'h106AA070;
            6'd48: round_const = 32'h19A4C116;  6'd49: round_const = 32'h1E376C08;
            6'd50: round_const = 32'h2748774C;  6'd51: round_const = 32'h34B0BCB5;
            6'd52: round_const = 32'h391C0CB3;  6'd53: round_const = 32'h4ED8AA4A;
            6'd54: round_const = 32'h5B9CCA4F;  6'd55: round_const = 32'h682E6FF3;
            6'd56: round_const = 32'h748F82EE;  6'd57: round_const = 32'h78A5636F;
            6'd58: round_const = 32'h84C87814;  6'd59: round_const = 32'h8CC70208;
            6'd60: round_const = 32'h90BEFFFA;  6'd61: round_const = 32'hA4506CEB;
            6'd62: round_const = 32'hBEF9A3F7;  default: round_const = 32'hC67178F2;
        endcase
    endfunction

endpackage

/* hw/rtl/sha256_round.sv */
`timescale 1ns / 1ps
module sha256_round
    import sha256_pkg::*;
(
    input  t_hash       i_work,
    input  t_word [3:0] i_taps,     // window words 0, 1, 9, 14
    input  logic [5:0]  i_round,
    output t_word       o_sched,    // word shifted into the window tail
    output t_hash       o_work
);
    t_word w;
    t_word t1;
    t_word t2;

    always_comb begin
        // first sixteen rounds use the loaded block; recycle it to the tail
        if (i_round[5:4] == 2'b00) begin
            w = i_taps[0];
        end else begin
            w = i_taps[0] + small_sig0(i_taps[1]) + i_taps[2] + small_sig1(i_taps[3]);
        end
        o_sched = w;
        t1 = i_work[7] + big_sig1(i_work[4])
           + ((i_work[4] & i_work[5]) ^ (~i_work[4] & i_work[6]))
           + round_const(i_round) + w;
        t2 = big_sig0(i_work[0])
           + ((i_work[0] & i_work[1]) ^ (i_work[0] & i_work[2]) ^ (i_work[1] & i_work[2]));
        o_work[7] = i_work[6];
        o_work[6] = i_work[5];
        o_work[5] = i_work[4];
        o_work[4] = i_work[3] + t1;
        o_work[3] = i_work[2];
        o_work[2] = i_work[1];
        o_work[1] = i_work[0];
        o_work[0] = t1 + t2;
    end
endmodule

/* hw/rtl/sha256_message_hasher.sv */
`timescale 1ns / 1ps
// SHA-256 hasher over a byte stream.
// Input channel: i_in_valid / o_in_stall carry one word per handshake: a
// message byte (when byte_present is set) and an optional end mark. A bare end
// mark finishes the message as it stands, so an empty message can be hashed.
// Output channel: o_out_valid / i_out_stall carry one word per message, the
// 256-bit digest plus a length-error flag (message reached 2^61 bytes).
// Each data byte is taken in a single handshake; every 64th byte also starts a
// block compression (the rounds through the one shared round unit, then the
// chain add). Padding then feeds 0x80, zeros and the 8 length bytes, with one
// or two compressions, before the digest shows. Sustained throughput is set
// by the single round unit.
// The block takes one word at a time: o_in_stall is high during a
// compression, and from the end mark until the digest has been taken.
// While the receiver stalls, the digest holds on o_out_word and no input is
// accepted. After the digest is taken the hasher is back in its reset state.
// Reset (i_rst_n low, synchronous) loads the initial hash and clears counts.
module sha256_message_hasher
    import sha256_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_stall,
    input  t_in_word  i_in_word,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_word o_out_word
);
    localparam logic [2:0] ST_IDLE     = 3'd0;
    localparam logic [2:0] ST_PAD_LEAD = 3'd1;
    localparam logic [2:0] ST_PAD_ZERO = 3'd2;
    localparam logic [2:0] ST_PAD_LEN  = 3'd3;
    localparam logic [2:0] ST_COMP     = 3'd4;
    localparam logic [2:0] ST_FINAL    = 3'd5;
    localparam logic [2:0] ST_OUT      = 3'd6;

    logic [2:0]  r_state, n_state;
    logic [2:0]  r_ret, n_ret;
    logic [5:0]  r_fill;
    logic [5:0]  r_round;
    logic [63:0] r_bits, n_bits;
    logic [63:0] r_len;
    logic        r_ovf, n_ovf;
    t_hash       r_chain;
    t_hash       r_work;
    t_word       r_win [16];

    logic        place;
    logic [7:0]  place_byte;
    logic        full;
    logic        accept;
    t_word [3:0] taps;
    t_word       sched;
    t_hash       work_next;

    assign accept      = i_in_valid && (r_state == ST_IDLE);
    assign o_in_stall  = (r_state != ST_IDLE);
    assign o_out_valid = (r_state == ST_OUT);
    assign full        = (r_fill == 6'd63);
    assign taps        = {r_win[14], r_win[9], r_win[1], r_win[0]};

    sha256_round u_round (
        .i_work  (r_work),
        .i_taps  (taps),
        .i_round (r_round),
        .o_sched (sched),
        .o_work  (work_next)
    );

    assign o_out_word.digest_high      = {r_chain[0], r_chain[1]};
    assign o_out_word.digest_upper_mid = {r_chain[2], r_chain[3]};
    assign o_out_word.digest_lower_mid = {r_chain[4], r_chain[5]};
    assign o_out_word.digest_low       = {r_chain[6], r_chain[7]};
    assign o_out_word.length_error     = r_ovf;

    // sequencer: pick the byte to place and where to go next
    always_comb begin
        n_state    = r_state;
        n_ret      = r_ret;
        n_bits     = r_bits;
        n_ovf      = r_ovf;
        place      = 1'b0;
        place_byte = 8'h00;
        unique case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    if (i_in_word.byte_present) begin
                        place      = 1'b1;
                        place_byte = i_in_word.msg_byte;
                        n_bits     = r_bits + 64'd8;
                        if (n_bits == 64'd0) begin
                            n_ovf = 1'b1;
                        end
                    end
                    if (i_in_word.end_of_message) begin
                        n_state = ST_PAD_LEAD;
                    end
                    if (place && full) begin
                        n_ret   = n_state;
                        n_state = ST_COMP;
                    end
                end
            end
            ST_PAD_LEAD: begin
                place      = 1'b1;
                place_byte = PAD_LEAD_BYTE;
                n_state    = full ? ST_COMP : ST_PAD_ZERO;
                n_ret      = ST_PAD_ZERO;
            end
            ST_PAD_ZERO: begin
                if (r_fill == LEN_FIELD_START) begin
                    n_state = ST_PAD_LEN;
                end else begin
                    place   = 1'b1;
                    n_ret   = ST_PAD_ZERO;
                    if (full) begin
                        n_state = ST_COMP;
                    end
                end
            end
            ST_PAD_LEN: begin
                place      = 1'b1;
                place_byte = r_len[63:56];
                if (full) begin
                    n_state = ST_COMP;
                    n_ret   = ST_OUT;
                end
            end
            ST_COMP: begin
                if (r_round == 6'd63) begin
                    n_state = ST_FINAL;
                end
            end
            ST_FINAL: begin
                n_state = r_ret;
            end
            ST_OUT: begin
                if (!i_out_stall) begin
                    n_state = ST_IDLE;
                    n_bits  = 64'd0;
                    n_ovf   = 1'b0;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_ret     <= ST_IDLE;
            r_fill    <= 6'd0;
            r_round   <= 6'd0;
            r_bits    <= 64'd0;
            r_ovf     <= 1'b0;
            r_chain   <= INIT_HASH;
            r_work    <= '0;
        end else begin
            r_state <= n_state;
            r_ret   <= n_ret;
            r_bits  <= n_bits;
            r_ovf   <= n_ovf;
            if (place) begin
                r_fill <= r_fill + 6'd1;
            end
            // latch the length at the end mark; shift it out during padding
            if (accept && i_in_word.end_of_message) begin
                r_len <= n_bits;
            end else if (r_state == ST_PAD_LEN) begin
                r_len     <= {r_len[55:0], 8'h00};
            end
            // block full: load working words from the chain
            if (place && full) begin
                r_work  <= r_chain;
                r_round <= 6'd0;
            end
            if (r_state == ST_COMP) begin
                r_work  <= work_next;
                r_round <= r_round + 6'd1;
            end
            if (r_state == ST_FINAL) begin
                for (int i = 0; i < 8; i++) begin
                    r_chain[i] <= r_chain[i] + r_work[i];
                end
            end
            if ((r_state == ST_OUT) && !i_out_stall) begin
                r_chain   <= INIT_HASH;
                r_work    <= '0;
            end
        end
    end

    // block buffer and rolling schedule window
    always_ff @(posedge i_clk) begin
        if (place) begin
            r_win[r_fill[5:2]] <= {r_win[r_fill[5:2]][23:0], place_byte};
        end else if (r_state == ST_COMP) begin
            for (int i = 0; i < 15; i++) begin
                r_win[i] <= r_win[i+1];
            end
            r_win[15] <= sched;
        end
    end

endmodule
